/* hdl/tzc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tzc_pkg
// Shared types and constants of the tilt zone classifier: CORDIC angle table,
// zone codes and register indexes.
// ----------------------------------------------------------------------------
package tzc_pkg;

    localparam int TAB_FRAC     = 20;
    localparam int CORDIC_ITERS = 22;
    localparam int ATAN_W       = 27;
    localparam int ZW           = 29;

    localparam logic [1:0] REG_LOW_THR  = 2'd0;
    localparam logic [1:0] REG_HIGH_THR = 2'd1;

    localparam logic [2:0] ZONE_CENTRE = 3'd2;
    localparam logic [2:0] ZONE_SECOND = 3'd4;
    localparam logic [2:0] ZONE_OUTER  = 3'd0;

    typedef struct packed {
        logic zero_den;
        logic num_neg;
        logic num_zero;
    } flags_t;

    // atan(2^-i) in degrees, 20 fraction bits
    function automatic logic [ATAN_W-1:0] atan_entry(input int i);
        logic [ATAN_W-1:0] v;
        case (i)
            0:       v = 27'd47185920;
            1:       v = 27'd27855475;
            2:       v = 27'd14718068;
            3:       v = 27'd7471121;
            4:       v = 27'd3750058;
            5:       v = 27'd1876857;
            6:       v = 27'd938658;
            7:       v = 27'd469357;
            8:       v = 27'd234682;
            9:       v = 27'd117342;
            10:      v = 27'd58671;
            11:      v = 27'd29335;
            12:      v = 27'd14668;
            13:      v = 27'd7334;
            14:      v = 27'd3667;
            15:      v = 27'd1833;
            16:      v = 27'd917;
            17:      v = 27'd458;
            18:      v = 27'd229;
            19:      v = 27'd115;
            20:      v = 27'd57;
            21:      v = 27'd29;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* hdl/accel_tilt_zone_classifier_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_tilt_zone_classifier_top
// Roll and pitch from a three-axis sample, classified into LED zones.
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle (busy is always low) and
// gives one result per item, in order. The pipeline is made of two rows
// of cells: one square root cell per root bit and 22 CORDIC cells, with
// two stages in front and two behind. The result is shown for one cycle
// with result_valid; there is no way to hold it off, so the receiver must
// take it then. Threshold writes are always accepted and take effect on
// results that leave after the write.
// ----------------------------------------------------------------------------
module accel_tilt_zone_classifier_top #(
    parameter int SAMPLE_BITS     = 10,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [SAMPLE_BITS-1:0] accel_x,
    input  logic [SAMPLE_BITS-1:0] accel_y,
    input  logic [SAMPLE_BITS-1:0] accel_z,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [6:0]             cfg_data,
    output logic                   result_valid,
    output logic signed [7:0]      pitch_deg,
    output logic signed [7:0]      roll_deg,
    output logic [2:0]             led_row,
    output logic [4:0]             led_row_bits
);

    localparam int S       = SAMPLE_BITS;
    localparam int F       = ANGLE_FRAC_BITS;
    localparam int SQW     = 2 * S;
    localparam int RW      = 2 * S + 2 * F;
    localparam int QW      = S + F;
    localparam int XW      = S + F + 3;
    localparam int ZW      = tzc_pkg::ZW;
    localparam int NIT     = tzc_pkg::CORDIC_ITERS;
    localparam int AW      = F + 8;
    localparam int TSH     = tzc_pkg::TAB_FRAC - F;
    localparam int LATENCY = QW + NIT + 4;

    // ninety degrees with F fraction bits, at both widths
    localparam logic signed [ZW-1:0] NINETY_Z = ZW'(90) <<< F;
    localparam logic signed [AW-1:0] NINETY_A = AW'(90) <<< F;

    // ---- handshake and configuration -------------------------------------
    logic [6:0]         low_thr_reg;
    logic [6:0]         high_thr_reg;
    logic [LATENCY-1:0] vld_reg;
    logic [LATENCY-1:0] vld_next;
    logic               accept;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign vld_next  = {vld_reg[LATENCY-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_thr_reg  <= 7'd20;
            high_thr_reg <= 7'd45;
            vld_reg      <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tzc_pkg::REG_LOW_THR:  low_thr_reg  <= cfg_data;
                    tzc_pkg::REG_HIGH_THR: high_thr_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // ---- stage 1: squares ------------------------------------------------
    logic signed [S-1:0]   sx_reg, sy_reg;
    logic [SQW-1:0]        xx_reg, yy_reg, zz_reg;
    logic signed [2*S-1:0] xx_p, yy_p, zz_p;

    assign xx_p = $signed(accel_x) * $signed(accel_x);
    assign yy_p = $signed(accel_y) * $signed(accel_y);
    assign zz_p = $signed(accel_z) * $signed(accel_z);

    always_ff @(posedge clk)
    begin
        sx_reg <= $signed(accel_x);
        sy_reg <= $signed(accel_y);
        xx_reg <= SQW'(xx_p);
        yy_reg <= SQW'(yy_p);
        zz_reg <= SQW'(zz_p);
    end

    // ---- stage 2: radicands, index 0 is roll and 1 is pitch ---------------
    logic [RW-1:0]      rem_c  [2][QW+1];
    logic [QW-1:0]      root_c [2][QW+1];
    logic [S-1:0]       num_c  [2][QW+1];

    always_ff @(posedge clk)
    begin
        rem_c[0][0]  <= {SQW'(xx_reg + zz_reg), {(2*F){1'b0}}};
        rem_c[1][0]  <= {SQW'(yy_reg + zz_reg), {(2*F){1'b0}}};
        root_c[0][0] <= '0;
        root_c[1][0] <= '0;
        num_c[0][0]  <= sy_reg;
        num_c[1][0]  <= sx_reg;
    end

    // ---- square root row: one root bit per cell, MSB first -----------------
    logic signed [XW-1:0] cx   [2][NIT+1];
    logic signed [XW-1:0] cy   [2][NIT+1];
    logic signed [ZW-1:0] cz   [2][NIT+1];
    tzc_pkg::flags_t      cf   [2][NIT+1];

    for (genvar a = 0; a < 2; a++)
    begin : g_angle
        for (genvar k = 0; k < QW; k++)
        begin : g_sqrt
            tzc_sqrt_cell #(
                .RW  (RW),
                .QW  (QW),
                .BIT (QW - 1 - k),
                .SBW (S)
            ) u_sqrt (
                .clk      (clk),
                .rem_in   (rem_c[a][k]),
                .root_in  (root_c[a][k]),
                .side_in  (num_c[a][k]),
                .rem_out  (rem_c[a][k+1]),
                .root_out (root_c[a][k+1]),
                .side_out (num_c[a][k+1])
            );
        end

        // Start vectoring from (root, numerator * 2^F); note the degenerate case.
        assign cx[a][0]          = $signed({{(XW-QW){1'b0}}, root_c[a][QW]});
        assign cy[a][0]          = XW'($signed(num_c[a][QW])) <<< F;
        assign cz[a][0]          = '0;
        assign cf[a][0].zero_den = (root_c[a][QW] == '0);
        assign cf[a][0].num_neg  = num_c[a][QW][S-1];
        assign cf[a][0].num_zero = (num_c[a][QW] == '0);

        for (genvar i = 0; i < NIT; i++)
        begin : g_cordic
            tzc_cordic_cell #(
                .XW  (XW),
                .IDX (i)
            ) u_cordic (
                .clk       (clk),
                .x_in      (cx[a][i]),
                .y_in      (cy[a][i]),
                .z_in      (cz[a][i]),
                .flags_in  (cf[a][i]),
                .x_out     (cx[a][i+1]),
                .y_out     (cy[a][i+1]),
                .z_out     (cz[a][i+1]),
                .flags_out (cf[a][i+1])
            );
        end
    end

    // ---- stage A: drop table fraction bits, clamp, degenerate case --------
    logic signed [AW-1:0] ang_reg  [2];
    logic signed [AW-1:0] ang_next [2];
    logic signed [ZW-1:0] zmag     [2];
    logic signed [ZW-1:0] ztr      [2];

    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            zmag[a] = cz[a][NIT][ZW-1] ? -cz[a][NIT] : cz[a][NIT];
            ztr[a]  = zmag[a] >>> TSH;
            if (cz[a][NIT][ZW-1])
                ztr[a] = -ztr[a];
            if (cf[a][NIT].zero_den)
            begin
                if (cf[a][NIT].num_zero)
                    ang_next[a] = '0;
                else if (cf[a][NIT].num_neg)
                    ang_next[a] = -NINETY_A;
                else
                    ang_next[a] = NINETY_A;
            end
            else if (ztr[a] > NINETY_Z)
                ang_next[a] = NINETY_A;
            else if (ztr[a] < -NINETY_Z)
                ang_next[a] = -NINETY_A;
            else
                ang_next[a] = AW'(ztr[a]);
        end
    end

    always_ff @(posedge clk)
    begin
        ang_reg[0] <= ang_next[0];
        ang_reg[1] <= ang_next[1];
    end

    // ---- stage B: whole degrees and zones ---------------------------------
    logic signed [AW-1:0] lo_a, hi_a;
    logic signed [AW-1:0] amag [2];
    logic signed [AW-1:0] adeg [2];
    logic [2:0]           zone [2];
    logic [4:0]           pitch_bits;

    assign lo_a = $signed({1'b0, low_thr_reg, {F{1'b0}}});
    assign hi_a = $signed({1'b0, high_thr_reg, {F{1'b0}}});

    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            amag[a] = ang_reg[a][AW-1] ? -ang_reg[a] : ang_reg[a];
            adeg[a] = amag[a] >>> F;
            if (ang_reg[a][AW-1])
                adeg[a] = -adeg[a];
            if (ang_reg[a] <= lo_a)
                zone[a] = tzc_pkg::ZONE_CENTRE;
            else if (ang_reg[a] <= hi_a)
                zone[a] = tzc_pkg::ZONE_SECOND;
            else
                zone[a] = tzc_pkg::ZONE_OUTER;
        end
        case (zone[1])
            tzc_pkg::ZONE_CENTRE: pitch_bits = 5'b00100;
            tzc_pkg::ZONE_SECOND: pitch_bits = 5'b10000;
            default:              pitch_bits = 5'b00001;
        endcase
    end

    always_ff @(posedge clk)
    begin
        roll_deg     <= 8'(adeg[0]);
        pitch_deg    <= 8'(adeg[1]);
        led_row      <= zone[0];
        led_row_bits <= pitch_bits;
    end

    assign result_valid = vld_reg[LATENCY-1];

endmodule

/* hdl/tzc_sqrt_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tzc_sqrt_cell
// One bit of a pipelined restoring integer square root; carries a side word.
// ----------------------------------------------------------------------------
module tzc_sqrt_cell #(
    parameter int RW  = 36,
    parameter int QW  = 18,
    parameter int BIT = 0,
    parameter int SBW = 10
) (
    input  logic           clk,
    input  logic [RW-1:0]  rem_in,
    input  logic [QW-1:0]  root_in,
    input  logic [SBW-1:0] side_in,
    output logic [RW-1:0]  rem_out,
    output logic [QW-1:0]  root_out,
    output logic [SBW-1:0] side_out
);

    localparam int TW = RW + 1;

    logic [TW-1:0] trial;
    logic [TW-1:0] rem_ext;
    logic          take;

    // (root + 2^b)^2 - root^2
    assign trial   = ({{(TW-QW){1'b0}}, root_in} << (BIT + 1)) + (TW'(1) << (2 * BIT));
    assign rem_ext = {1'b0, rem_in};
    assign take    = (rem_ext >= trial);

    always_ff @(posedge clk)
    begin
        rem_out  <= take ? RW'(rem_ext - trial) : rem_in;
        root_out <= take ? (root_in | (QW'(1) << BIT)) : root_in;
        side_out <= side_in;
    end

endmodule

/* hdl/tzc_cordic_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tzc_cordic_cell
// One CORDIC vectoring iteration with a fixed shift and table angle.
// ----------------------------------------------------------------------------
module tzc_cordic_cell #(
    parameter int XW  = 21,
    parameter int IDX = 0
) (
    input  logic                         clk,
    input  logic signed [XW-1:0]         x_in,
    input  logic signed [XW-1:0]         y_in,
    input  logic signed [tzc_pkg::ZW-1:0] z_in,
    input  tzc_pkg::flags_t              flags_in,
    output logic signed [XW-1:0]         x_out,
    output logic signed [XW-1:0]         y_out,
    output logic signed [tzc_pkg::ZW-1:0] z_out,
    output tzc_pkg::flags_t              flags_out
);

    logic signed [XW-1:0]          dx;
    logic signed [XW-1:0]          dy;
    logic signed [tzc_pkg::ZW-1:0] ang;

    assign dx  = y_in >>> IDX;
    assign dy  = x_in >>> IDX;
    assign ang = $signed({{(tzc_pkg::ZW-tzc_pkg::ATAN_W){1'b0}}, tzc_pkg::atan_entry(IDX)});

    always_ff @(posedge clk)
    begin
        if (!y_in[XW-1])
        begin
            x_out <= x_in + dx;
            y_out <= y_in - dy;
            z_out <= z_in + ang;
        end
        else
        begin
            x_out <= x_in - dx;
            y_out <= y_in + dy;
            z_out <= z_in - ang;
        end
        flags_out <= flags_in;
    end

endmodule

/* hdl/tzc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tzc_checker
// Port-level checks of the tilt zone classifier, bound to the top level.
// ----------------------------------------------------------------------------
module tzc_checker #(
    parameter int LATENCY = 44
) (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              result_valid,
    input logic signed [7:0] pitch_deg,
    input logic signed [7:0] roll_deg,
    input logic [2:0]        led_row,
    input logic [4:0]        led_row_bits
);

    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY result_valid)
        else $error("item did not produce a result at the fixed latency");

    a_row_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (led_row == tzc_pkg::ZONE_CENTRE ||
                          led_row == tzc_pkg::ZONE_SECOND ||
                          led_row == tzc_pkg::ZONE_OUTER))
        else $error("led_row is not a zone code");

    a_bits_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (led_row_bits == 5'b00001 || led_row_bits == 5'b00100 ||
                          led_row_bits == 5'b10000))
        else $error("led_row_bits is not a zone pattern");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (pitch_deg <= 8'sd90 && pitch_deg >= -8'sd90 &&
                          roll_deg <= 8'sd90 && roll_deg >= -8'sd90))
        else $error("angle beyond ninety degrees");

endmodule

bind accel_tilt_zone_classifier_top tzc_checker #(
    .LATENCY (LATENCY)
) u_tzc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .pitch_deg    (pitch_deg),
    .roll_deg     (roll_deg),
    .led_row      (led_row),
    .led_row_bits (led_row_bits)
);
